@@ hw/rtl/bounded_deque_with_value_delete_top_assert.svh @@
// Assertion macros shared by the deque RTL.
// Included by the datapath and controller modules; no other dependencies.
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDQ_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDQ_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bdq_pkg.sv @@
// Shared types and constants for the bounded deque.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 4;
  localparam int ST_W         = 2;
  localparam int LEN_W        = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 4'd0,
    MODE_PUSH_BACK  = 4'd1,
    MODE_POP_FRONT  = 4'd2,
    MODE_POP_BACK   = 4'd3,
    MODE_DELETE     = 4'd4,
    MODE_RD_FIRST   = 4'd5,
    MODE_RD_LAST    = 4'd6,
    MODE_RD_ALL     = 4'd7,
    MODE_CLEAR      = 4'd8
  } mode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } st_t;

  // Offset source for the store address.
  typedef enum logic [1:0] {
    ADDR_POS  = 2'd0,
    ADDR_POS1 = 2'd1,
    ADDR_CNT  = 2'd2,
    ADDR_FDEC = 2'd3
  } addr_sel_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic      latch;
    logic      load_lim;
    logic      pos_clr;
    logic      pos_init;
    logic      pos_inc;
    logic      push_front;
    logic      push_back;
    logic      pop_front;
    logic      pop_back;
    logic      dec_count;
    logic      clear;
    logic      mem_we;
    addr_sel_t addr_sel;
    logic      emit;
    logic      emit_data;
    logic      emit_last;
    st_t       st;
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              empty;
    logic              full;
    logic              k_zero;
    logic              pos_last;
    logic              pos_last2;
    logic              match;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bdq_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// Depends on bdq_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram
  import bdq_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bdq_dp.sv @@
// Deque datapath: front/count registers, walk pointer, element store, result registers.
// Depends on bdq_pkg, bdq_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_value_delete_top_assert.svh"

module bdq_dp
  import bdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [MODE_W-1:0]        mode,
  input  wire logic signed [DATA_W-1:0] operand,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  output logic                          strobe,
  output logic signed [DATA_W-1:0]      element,
  output logic                          has_element,
  output logic                          last_of_run,
  output logic [ST_W-1:0]               status,
  output logic [LEN_W-1:0]              length
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int SUMW = IDXW + 2;

  logic [MODE_W-1:0]        mode_q;
  logic signed [DATA_W-1:0] operand_q;
  logic [IDXW-1:0]          front, front_next, front_dec, front_inc;
  logic [CNTW-1:0]          count, count_next;
  logic [CNTW-1:0]          pos, lim, take, pos_start, lim_val;
  logic [CNTW:0]            pos_p1;
  logic [CNTW:0]            offset;
  logic [SUMW-1:0]          slot_sum;
  logic [IDXW-1:0]          addr;
  logic [DATA_W-1:0]        wdata, rdata;
  logic                     k_pos, k_big;

  // circular front pointer moves
  assign front_dec = (front == '0) ? IDXW'(CAPACITY - 1) : front - 1'b1;
  assign front_inc = (front == IDXW'(CAPACITY - 1)) ? '0 : front + 1'b1;

  // clamp k to [0, count]
  assign k_pos = !operand_q[DATA_W-1] && (operand_q != '0);
  assign k_big = $unsigned(operand_q) > DATA_W'(count);
  always_comb begin
    if (mode_q == MODE_RD_ALL) begin
      take = count;
    end else if (!k_pos) begin
      take = '0;
    end else if (k_big) begin
      take = count;
    end else begin
      take = operand_q[CNTW-1:0];
    end
  end

  assign pos_start = (mode_q == MODE_RD_LAST) ? count - take : '0;
  assign lim_val   = (mode_q == MODE_RD_FIRST) ? take : count;
  assign pos_p1    = (CNTW+1)'(pos) + 1'b1;

  // physical slot = (front + offset) mod CAPACITY, sum stays below 2*CAPACITY
  always_comb begin
    case (cmd.addr_sel)
      ADDR_POS:  offset = (CNTW+1)'(pos);
      ADDR_POS1: offset = pos_p1;
      ADDR_CNT:  offset = (CNTW+1)'(count);
      default:   offset = '0;
    endcase
    slot_sum = SUMW'(front) + SUMW'(offset);
    if (cmd.addr_sel == ADDR_FDEC) begin
      addr = front_dec;
    end else if (slot_sum >= SUMW'(CAPACITY)) begin
      addr = IDXW'(slot_sum - SUMW'(CAPACITY));
    end else begin
      addr = slot_sum[IDXW-1:0];
    end
  end

  assign wdata = (cmd.push_front || cmd.push_back) ? operand_q : rdata;

  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (cmd.mem_we),
    .waddr(addr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    count_next = count;
    front_next = front;
    if (cmd.clear) begin
      count_next = '0;
      front_next = '0;
    end else if (cmd.push_front) begin
      count_next = count + 1'b1;
      front_next = front_dec;
    end else if (cmd.push_back) begin
      count_next = count + 1'b1;
    end else if (cmd.pop_front) begin
      count_next = count - 1'b1;
      front_next = front_inc;
    end else if (cmd.pop_back || cmd.dec_count) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front  <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      front  <= front_next;
      count  <= count_next;
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q    <= mode;
      operand_q <= operand;
    end
    if (cmd.load_lim) begin
      lim <= lim_val;
    end
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.pos_init) begin
      pos <= pos_start;
    end else if (cmd.pos_inc) begin
      pos <= pos_p1[CNTW-1:0];
    end
    if (cmd.emit) begin
      element     <= cmd.emit_data ? $signed(rdata) : '0;
      has_element <= cmd.emit_data;
      last_of_run <= cmd.emit_last;
      status      <= cmd.st;
      length      <= LEN_W'(count_next);
    end
  end

  always_comb begin
    sts.mode      = mode_q;
    sts.empty     = (count == '0);
    sts.full      = (count == CNTW'(CAPACITY));
    sts.k_zero    = (take == '0);
    sts.pos_last  = (pos_p1 == (CNTW+1)'(lim));
    sts.pos_last2 = ((CNTW+1)'(pos) + 2'd2 == (CNTW+1)'(lim));
    sts.match     = ($signed(rdata) == operand_q);
  end

  `BDQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNTW'(CAPACITY), "count over capacity")
  `BDQ_ASSERT_NXT(a_push_grows, clk, rst, cmd.push_front || cmd.push_back, count == $past(count) + 1'b1, "push did not grow count")
  `BDQ_ASSERT_NXT(a_strobe_gap, clk, rst, strobe, !strobe, "results back to back")

endmodule

`default_nettype wire

@@ hw/rtl/bdq_ctrl.sv @@
// Deque controller FSM: decodes a command and sequences walks over the store.
// Depends on bdq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_value_delete_top_assert.svh"

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_DL_RD  = 8'b0000_0100,
    S_DL_CMP = 8'b0000_1000,
    S_SH_RD  = 8'b0001_0000,
    S_SH_WR  = 8'b0010_0000,
    S_RO_RD  = 8'b0100_0000,
    S_RO_OUT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.st     = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.latch = start;
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        // single-result commands finish here
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
        cmd.load_lim  = 1'b1;
        case (sts.mode)
          MODE_PUSH_FRONT: begin
            if (sts.full) begin
              cmd.st = ST_FULL;
            end else begin
              cmd.push_front = 1'b1;
              cmd.mem_we     = 1'b1;
              cmd.addr_sel   = ADDR_FDEC;
            end
          end
          MODE_PUSH_BACK: begin
            if (sts.full) begin
              cmd.st = ST_FULL;
            end else begin
              cmd.push_back = 1'b1;
              cmd.mem_we    = 1'b1;
              cmd.addr_sel  = ADDR_CNT;
            end
          end
          MODE_POP_FRONT: begin
            if (sts.empty) begin
              cmd.st = ST_EMPTY;
            end else begin
              cmd.pop_front = 1'b1;
            end
          end
          MODE_POP_BACK: begin
            if (sts.empty) begin
              cmd.st = ST_EMPTY;
            end else begin
              cmd.pop_back = 1'b1;
            end
          end
          MODE_DELETE: begin
            if (sts.empty) begin
              cmd.st = ST_EMPTY;
            end else begin
              cmd.emit      = 1'b0;
              cmd.emit_last = 1'b0;
              cmd.pos_clr   = 1'b1;
              state_next    = S_DL_RD;
            end
          end
          MODE_RD_FIRST, MODE_RD_LAST, MODE_RD_ALL: begin
            if (sts.empty) begin
              cmd.st = ST_EMPTY;
            end else if (!sts.k_zero) begin
              cmd.emit      = 1'b0;
              cmd.emit_last = 1'b0;
              cmd.pos_init  = 1'b1;
              state_next    = S_RO_RD;
            end
          end
          MODE_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_DL_RD: begin
        cmd.addr_sel = ADDR_POS;
        state_next   = S_DL_CMP;
      end
      S_DL_CMP: begin
        if (sts.match) begin
          if (sts.pos_last) begin
            // back element removed: just shrink
            cmd.dec_count = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_SH_RD;
          end
        end else if (sts.pos_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.st        = ST_MISSING;
          state_next    = S_IDLE;
        end else begin
          cmd.pos_inc = 1'b1;
          state_next  = S_DL_RD;
        end
      end
      S_SH_RD: begin
        cmd.addr_sel = ADDR_POS1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.addr_sel = ADDR_POS;
        cmd.mem_we   = 1'b1;
        if (sts.pos_last2) begin
          cmd.dec_count = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.pos_inc = 1'b1;
          state_next  = S_SH_RD;
        end
      end
      S_RO_RD: begin
        cmd.addr_sel = ADDR_POS;
        state_next   = S_RO_OUT;
      end
      S_RO_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_data = 1'b1;
        cmd.emit_last = sts.pos_last;
        cmd.pos_inc   = 1'b1;
        state_next    = sts.pos_last ? S_IDLE : S_RO_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BDQ_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted command not started")
  `BDQ_ASSERT_NXT(a_last_idle, clk, rst, cmd.emit && cmd.emit_last, !busy, "still busy after final result")

endmodule

`default_nettype wire

@@ hw/rtl/bounded_deque_with_value_delete_top.sv @@
// Top level of the bounded deque with value delete.
// Depends on bdq_pkg, bdq_ctrl, bdq_dp (and bdq_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Usage notes
// - Command channel: drive mode/operand and raise start; the transfer happens
//   on the rising edge where start is high and busy is low. busy stays high
//   until the command's final result has been loaded into the output regs.
// - Result channel: each result shows on element/has_element/last_of_run/
//   status/length for exactly one cycle with strobe high. The receiver cannot
//   stall, so results are never held; last_of_run marks the final one.
// - Push, pop, clear, unused mode codes, readouts with no data and empty/full
//   errors: finish in S_DECODE, which loads the single result; busy drops as
//   strobe rises, so a new command can go once that result is loaded.
// - Readouts of k elements: each element takes an address step (S_RO_RD)
//   for the registered RAM read, then an emit step (S_RO_OUT); the results
//   come one at a time and the next command waits until busy drops.
// - Value delete on n elements: a read and a compare step per element up to
//   the match, then a read and a write step per element shifted down one slot
//   after it (both steps use the store's one shared address); a hit or a miss
//   alike ends with a single result and busy dropping.
// - Reset (rst, synchronous): list empty, front slot 0, no result pending;
//   the element store needs no clearing pass, since only held slots are read.
module bounded_deque_with_value_delete_top
  import bdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [MODE_W-1:0]        mode,
  input  wire logic signed [DATA_W-1:0] operand,
  output logic                          strobe,
  output logic signed [DATA_W-1:0]      element,
  output logic                          has_element,
  output logic                          last_of_run,
  output logic [ST_W-1:0]               status,
  output logic [LEN_W-1:0]              length
);

  cmd_t cmd;   // controller commands to the datapath
  sts_t sts;   // datapath flags back to the controller

  // sequencing: decode, delete walk/shift, readout walk
  bdq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  // pointers, store and result registers
  bdq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .operand    (operand),
    .cmd        (cmd),
    .sts        (sts),
    .strobe     (strobe),
    .element    (element),
    .has_element(has_element),
    .last_of_run(last_of_run),
    .status     (status),
    .length     (length)
  );

endmodule

`default_nettype wire
